// ===== hw/rtl/per_client_response_token_bucket_defines.svh =====
`ifndef PER_CLIENT_RESPONSE_TOKEN_BUCKET_DEFINES_SVH
`define PER_CLIENT_RESPONSE_TOKEN_BUCKET_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define PCRTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define PCRTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pcrtb_pkg.sv =====
`timescale 1ns / 1ps

package pcrtb_pkg;

	localparam int ENTRIES      = 1024;
	localparam int ADDR_W       = $clog2(ENTRIES);
	localparam int MAX_LOG_SECS = 1800;
	localparam int SKEW_LIMIT   = 5;

	localparam int RATE_W = 10;
	localparam int WIN_W  = 12;
	localparam int SLIP_W = 4;
	localparam int LC_W   = 11;
	localparam int TIME_W = 32;
	localparam int BAL_W  = 32;
	localparam int PROD_W = RATE_W + WIN_W;
	localparam int CALC_W = BAL_W + 2;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 8;
	localparam int CFG_ADDR_W = 5;

	localparam logic [1:0] CLS_OK = 2'd0;
	localparam logic [1:0] CLS_NX = 2'd1;

	localparam logic [1:0] VERDICT_PASS = 2'd0;
	localparam logic [1:0] VERDICT_DROP = 2'd1;
	localparam logic [1:0] VERDICT_SLIP = 2'd2;

	localparam logic [2:0] REG_OK_RATE = 3'd0;
	localparam logic [2:0] REG_NX_RATE = 3'd1;
	localparam logic [2:0] REG_ER_RATE = 3'd2;
	localparam logic [2:0] REG_WINDOW  = 3'd3;
	localparam logic [2:0] REG_SLIP    = 3'd4;

	typedef struct packed {
		logic [BAL_W-1:0]  bal;
		logic [TIME_W-1:0] last;
		logic [SLIP_W-1:0] slip;
		logic [LC_W-1:0]   lc;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL1,
		ST_MUL2,
		ST_UPD
	} state_t;

endpackage

// ===== hw/rtl/pcrtb_ram.sv =====
`timescale 1ns / 1ps

module pcrtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/per_client_response_token_bucket.sv =====
// Per-entry response rate limiter. Each request on the s_ side names a table entry, a response
// class and the time in seconds; one result (pass, drop or slip, plus continuing and log-due
// flags) comes out on the m_ side for each request. From acceptance to the result register each
// request goes through one read of the entry memory, two passes through the shared
// rate multiplier (debt floor, then credit), and one update step that writes the entry back.
// The next request is taken only after the state machine returns to idle from the update.
// A result waiting on m_tready holds the next write-back but not the acceptance of a request.
// After reset all 1024 entries of the entry memory are cleared, during which no request is taken;
// configuration writes over the APB port are taken at any time and should happen while idle.
`timescale 1ns / 1ps
`include "per_client_response_token_bucket_defines.svh"

module per_client_response_token_bucket (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// entry_index[9:0], now_secs[41:10], zero[47:42]
	input  logic [pcrtb_pkg::S_TDATA_W-1:0]      s_tdata,
	// response_class[1:0], recycled[2]
	input  logic [pcrtb_pkg::S_TUSER_W-1:0]      s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// verdict[1:0], continuing[2], log_due[3], zero[7:4]
	output logic [pcrtb_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pcrtb_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	localparam logic signed [pcrtb_pkg::CALC_W-1:0] SKEW_NEG =
		-pcrtb_pkg::CALC_W'(pcrtb_pkg::SKEW_LIMIT);

	pcrtb_pkg::state_t state_q, state_nxt;

	logic [pcrtb_pkg::RATE_W-1:0] ok_rate_q, nx_rate_q, er_rate_q;
	logic [pcrtb_pkg::WIN_W-1:0]  window_q;
	logic [pcrtb_pkg::SLIP_W-1:0] slip_every_q;
	logic                         cfg_wr;
	logic [2:0]                   cfg_idx;

	logic [pcrtb_pkg::ADDR_W-1:0] clr_q;
	logic [pcrtb_pkg::ADDR_W-1:0] idx_q;
	logic [1:0]                   cls_q;
	logic [pcrtb_pkg::TIME_W-1:0] now_q;
	logic                         rec_q;

	pcrtb_pkg::entry_t            ent_q;
	pcrtb_pkg::entry_t            ram_rdata, ram_wdata, upd_ent;
	logic                         ram_we;
	logic [pcrtb_pkg::ADDR_W-1:0] ram_waddr;

	logic [pcrtb_pkg::TIME_W-1:0] secs_q, secs_d, last_eff, diff;
	logic [pcrtb_pkg::PROD_W-1:0] floor_q, prod_q, mul_p;
	logic [pcrtb_pkg::WIN_W-1:0]  mul_b;
	logic [pcrtb_pkg::RATE_W-1:0] rate;

	logic                         m_tvalid_q;
	logic [pcrtb_pkg::M_TDATA_W-1:0] m_tdata_q, upd_out;
	logic                         accept, load_out;

	logic signed [pcrtb_pkg::CALC_W-1:0] bal_c, sum_c, b_c, b1_c, floor_c, rate_c;
	logic                         pos, big, cont;
	logic [pcrtb_pkg::LC_W-1:0]   lc_base, lc_new;
	logic [pcrtb_pkg::LC_W:0]     lc_sum;
	logic [pcrtb_pkg::SLIP_W-1:0] slip_new;
	logic [pcrtb_pkg::SLIP_W:0]   slip_inc;
	logic [1:0]                   verdict;
	logic                         logd;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_rate_q    <= '0;
			nx_rate_q    <= '0;
			er_rate_q    <= '0;
			window_q     <= pcrtb_pkg::WIN_W'(15);
			slip_every_q <= pcrtb_pkg::SLIP_W'(2);
		end else if (cfg_wr) begin
			case (cfg_idx)
				pcrtb_pkg::REG_OK_RATE: ok_rate_q    <= pwdata[pcrtb_pkg::RATE_W-1:0];
				pcrtb_pkg::REG_NX_RATE: nx_rate_q    <= pwdata[pcrtb_pkg::RATE_W-1:0];
				pcrtb_pkg::REG_ER_RATE: er_rate_q    <= pwdata[pcrtb_pkg::RATE_W-1:0];
				pcrtb_pkg::REG_WINDOW:  window_q     <= pwdata[pcrtb_pkg::WIN_W-1:0];
				pcrtb_pkg::REG_SLIP:    slip_every_q <= pwdata[pcrtb_pkg::SLIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			pcrtb_pkg::REG_OK_RATE: prdata = 32'(ok_rate_q);
			pcrtb_pkg::REG_NX_RATE: prdata = 32'(nx_rate_q);
			pcrtb_pkg::REG_ER_RATE: prdata = 32'(er_rate_q);
			pcrtb_pkg::REG_WINDOW:  prdata = 32'(window_q);
			pcrtb_pkg::REG_SLIP:    prdata = 32'(slip_every_q);
			default:                prdata = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcrtb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			pcrtb_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == pcrtb_pkg::ADDR_W'(pcrtb_pkg::ENTRIES - 1)) begin
					state_nxt = pcrtb_pkg::ST_IDLE;
				end
			end
			pcrtb_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = pcrtb_pkg::ST_READ;
				end
			end
			pcrtb_pkg::ST_READ: state_nxt = pcrtb_pkg::ST_MUL1;
			pcrtb_pkg::ST_MUL1: state_nxt = pcrtb_pkg::ST_MUL2;
			pcrtb_pkg::ST_MUL2: state_nxt = pcrtb_pkg::ST_UPD;
			pcrtb_pkg::ST_UPD: begin
				if (!m_tvalid_q || m_tready) begin
					ram_we    = 1'b1;
					load_out  = 1'b1;
					state_nxt = pcrtb_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pcrtb_pkg::ST_CLEAR;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == pcrtb_pkg::ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= s_tdata[pcrtb_pkg::ADDR_W-1:0];
			now_q <= s_tdata[41:10];
			cls_q <= s_tuser[1:0];
			rec_q <= s_tuser[2];
		end
	end

	// entry memory
	assign ram_waddr = (state_q == pcrtb_pkg::ST_CLEAR) ? clr_q : idx_q;
	assign ram_wdata = (state_q == pcrtb_pkg::ST_CLEAR) ? '0 : upd_ent;

	pcrtb_ram #(
		.WIDTH ($bits(pcrtb_pkg::entry_t)),
		.DEPTH (pcrtb_pkg::ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// rate of the class and elapsed seconds from the entry just read
	always_comb begin
		case (cls_q)
			pcrtb_pkg::CLS_OK: rate = ok_rate_q;
			pcrtb_pkg::CLS_NX: rate = nx_rate_q;
			default:           rate = er_rate_q;
		endcase
		last_eff = rec_q ? '0 : ram_rdata.last;
		diff     = now_q - last_eff;
		if (!diff[pcrtb_pkg::TIME_W-1]) begin
			secs_d = diff;
		end else if ($signed({{2{diff[pcrtb_pkg::TIME_W-1]}}, diff}) < SKEW_NEG) begin
			secs_d = now_q;
		end else begin
			secs_d = '0;
		end
	end

	// shared multiplier: window * rate, then rate * elapsed
	assign mul_b = (state_q == pcrtb_pkg::ST_MUL1) ? window_q :
		secs_q[pcrtb_pkg::WIN_W-1:0];
	assign mul_p = pcrtb_pkg::PROD_W'(rate) * pcrtb_pkg::PROD_W'(mul_b);

	always_ff @(posedge clk) begin
		if (state_q == pcrtb_pkg::ST_MUL1) begin
			ent_q   <= '{bal: ram_rdata.bal, last: last_eff, slip: ram_rdata.slip,
				lc: ram_rdata.lc};
			secs_q  <= secs_d;
			floor_q <= mul_p;
		end
		if (state_q == pcrtb_pkg::ST_MUL2) begin
			prod_q <= mul_p;
		end
	end

	// entry update and verdict
	always_comb begin
		rate_c  = pcrtb_pkg::CALC_W'(rate);
		bal_c   = {{2{ent_q.bal[pcrtb_pkg::BAL_W-1]}}, ent_q.bal};
		sum_c   = bal_c + pcrtb_pkg::CALC_W'(prod_q);
		floor_c = -pcrtb_pkg::CALC_W'(floor_q);
		pos     = !secs_q[pcrtb_pkg::TIME_W-1] && (secs_q != '0);
		big     = secs_q > pcrtb_pkg::TIME_W'(window_q);
		cont    = 1'b0;
		b_c     = bal_c;
		lc_base = ent_q.lc;
		slip_new = ent_q.slip;
		lc_new  = ent_q.lc;
		lc_sum  = '0;
		if (!pos) begin
			cont = bal_c < 0;
		end else begin
			if (big || sum_c > rate_c) begin
				b_c      = rate_c;
				lc_base  = pcrtb_pkg::LC_W'(pcrtb_pkg::MAX_LOG_SECS);
				slip_new = '0;
			end else begin
				b_c  = sum_c;
				cont = sum_c <= 0;
			end
			lc_sum = {1'b0, lc_base} + {1'b0, secs_q[pcrtb_pkg::LC_W-1:0]};
			if (secs_q[pcrtb_pkg::TIME_W-1:pcrtb_pkg::LC_W] != '0 ||
			    lc_sum > (pcrtb_pkg::LC_W+1)'(pcrtb_pkg::MAX_LOG_SECS)) begin
				lc_new = pcrtb_pkg::LC_W'(pcrtb_pkg::MAX_LOG_SECS);
			end else begin
				lc_new = lc_sum[pcrtb_pkg::LC_W-1:0];
			end
		end
		b1_c     = b_c - 1;
		verdict  = pcrtb_pkg::VERDICT_PASS;
		logd     = 1'b0;
		slip_inc = {1'b0, slip_new} + 1'b1;
		if (b1_c < 0) begin
			if (b1_c < floor_c) begin
				b1_c = floor_c;
			end
			verdict = pcrtb_pkg::VERDICT_DROP;
			if (slip_every_q != '0) begin
				if (slip_inc >= {1'b0, slip_every_q}) begin
					slip_new = '0;
					verdict  = pcrtb_pkg::VERDICT_SLIP;
				end else begin
					slip_new = slip_inc[pcrtb_pkg::SLIP_W-1:0];
				end
			end
			if (lc_new >= pcrtb_pkg::LC_W'(pcrtb_pkg::MAX_LOG_SECS)) begin
				lc_new = '0;
				logd   = 1'b1;
			end
		end
		if (rate == '0) begin
			upd_ent = ent_q;
			upd_out = '0;
		end else begin
			upd_ent.bal  = b1_c[pcrtb_pkg::BAL_W-1:0];
			upd_ent.last = now_q;
			upd_ent.slip = slip_new;
			upd_ent.lc   = lc_new;
			upd_out      = {4'b0, logd, cont, verdict};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= upd_out;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PCRTB_ASSERT_NOW(a_verdict_code, m_tvalid, m_tdata[1:0] != 2'b11, "bad verdict code")
	`PCRTB_ASSERT_NOW(a_log_limited, m_tvalid && m_tdata[3],
		m_tdata[1:0] != pcrtb_pkg::VERDICT_PASS, "log due on a passed response")
	`PCRTB_ASSERT_NEXT(a_one_in_flight, accept, !s_tready, "request taken while busy")
	`PCRTB_ASSERT_NOW(a_write_state, ram_we,
		state_q == pcrtb_pkg::ST_UPD || state_q == pcrtb_pkg::ST_CLEAR, "stray entry write")

endmodule

// ===== tb/sv/pcrtb_decision_checker.sv =====
`timescale 1ns / 1ps

module pcrtb_decision_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// entry_index[9:0], now_secs[41:10], zero[47:42]
	input  logic [pcrtb_pkg::S_TDATA_W-1:0]  s_tdata,
	// response_class[1:0], recycled[2]
	input  logic [pcrtb_pkg::S_TUSER_W-1:0]  s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// verdict[1:0], continuing[2], log_due[3], zero[7:4]
	input  logic [pcrtb_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pcrtb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                      pwdata,
	input  logic                             pready,
	output int                               mismatches,
	output int                               pending
);
	import pcrtb_pkg::*;

	typedef struct packed {
		logic [1:0] verdict;
		logic       continuing;
		logic       log_due;
	} decision_t;

	logic [BAL_W-1:0]  balance    [ENTRIES];
	logic [TIME_W-1:0] last_use   [ENTRIES];
	logic [SLIP_W-1:0] slip_tally [ENTRIES];
	logic [LC_W-1:0]   log_clk    [ENTRIES];

	logic [RATE_W-1:0] ok_rate, nx_rate, er_rate;
	logic [WIN_W-1:0]  window;
	logic [SLIP_W-1:0] slip_every;

	decision_t decision_q[$];

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic decision_t predict_decision(input logic [ADDR_W-1:0] idx,
			input logic [1:0] cls, input logic [TIME_W-1:0] now, input logic rec);
		decision_t r;
		longint rate, win, floor_v, secs, bal, lc, d;
		logic [TIME_W-1:0] diff;
		int unsigned c;
		r = '0;
		r.verdict = VERDICT_PASS;
		if (rec)
			last_use[idx] = '0;
		case (cls)
			CLS_OK: rate = ok_rate;
			CLS_NX: rate = nx_rate;
			default: rate = er_rate;
		endcase
		if (rate == 0)
			return r;
		win = window;
		floor_v = -win * rate;
		bal = $signed(balance[idx]);
		diff = now - last_use[idx];
		d = $signed(diff);
		if (d >= 0)
			secs = d;
		else if (d < -SKEW_LIMIT)
			secs = $signed(now);
		else
			secs = 0;
		if (secs <= 0) begin
			if (bal < 0)
				r.continuing = 1'b1;
		end else begin
			if (secs > win) begin
				log_clk[idx] = LC_W'(MAX_LOG_SECS);
				bal = rate;
				slip_tally[idx] = '0;
			end else begin
				bal = bal + rate * secs;
				if (bal > rate) begin
					log_clk[idx] = LC_W'(MAX_LOG_SECS);
					bal = rate;
					slip_tally[idx] = '0;
				end else if (bal <= 0) begin
					r.continuing = 1'b1;
				end
			end
			lc = longint'(log_clk[idx]) + secs;
			if (lc > MAX_LOG_SECS)
				lc = MAX_LOG_SECS;
			log_clk[idx] = lc[LC_W-1:0];
		end
		last_use[idx] = now;
		bal = bal - 1;
		if (bal >= 0) begin
			balance[idx] = bal[BAL_W-1:0];
			return r;
		end
		if (bal < floor_v)
			bal = floor_v;
		balance[idx] = bal[BAL_W-1:0];
		r.verdict = VERDICT_DROP;
		if (slip_every != 0) begin
			c = int'(slip_tally[idx]) + 1;
			if (c >= slip_every) begin
				slip_tally[idx] = '0;
				r.verdict = VERDICT_SLIP;
			end else begin
				slip_tally[idx] = c[SLIP_W-1:0];
			end
		end
		if (log_clk[idx] >= MAX_LOG_SECS) begin
			log_clk[idx] = '0;
			r.log_due = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decision_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				balance[i] = '0;
				last_use[i] = '0;
				slip_tally[i] = '0;
				log_clk[i] = '0;
			end
			ok_rate = '0;
			nx_rate = '0;
			er_rate = '0;
			window = WIN_W'(15);
			slip_every = SLIP_W'(2);
			decision_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (decision_q.size() == 0) begin
					report_mismatch("result with no request waiting", m_tdata, 0);
				end else begin
					want = decision_q.pop_front();
					if (m_tdata[1:0] != want.verdict)
						report_mismatch("verdict", m_tdata[1:0], want.verdict);
					if (m_tdata[2] != want.continuing)
						report_mismatch("continuing", m_tdata[2], want.continuing);
					if (m_tdata[3] != want.log_due)
						report_mismatch("log_due", m_tdata[3], want.log_due);
				end
			end
			if (s_tvalid && s_tready)
				decision_q.push_back(predict_decision(s_tdata[ADDR_W-1:0], s_tuser[1:0],
					s_tdata[ADDR_W +: TIME_W], s_tuser[2]));
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_ADDR_W-1:2])
					REG_OK_RATE: ok_rate = pwdata[RATE_W-1:0];
					REG_NX_RATE: nx_rate = pwdata[RATE_W-1:0];
					REG_ER_RATE: er_rate = pwdata[RATE_W-1:0];
					REG_WINDOW: window = pwdata[WIN_W-1:0];
					REG_SLIP: slip_every = pwdata[SLIP_W-1:0];
					default: ;
				endcase
			end
			pending <= decision_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_per_client_response_token_bucket.sv =====
`timescale 1ns / 1ps

module tb_per_client_response_token_bucket;
	import pcrtb_pkg::*;

	localparam logic [1:0] CLS_ERR   = 2'd2;
	localparam logic [1:0] CLS_SPARE = 2'd3;
	localparam int NUM_PHASES  = 7;
	localparam int PHASE_ITEMS = 112;
	localparam int MODE_ITEMS  = 268;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic [S_TUSER_W-1:0]  s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr    = '0;
	logic [31:0]           pwdata   = '0;
	logic [31:0]           prdata;
	logic                  pready;

	int mismatch_count;
	int pending_results;
	int send_idle = 37;
	int recv_idle = 56;
	int items_sent = 0;
	bit [TIME_W-1:0] entry_time [ENTRIES];

	int phase_ok   [NUM_PHASES] = '{1, 0, 5, 2, 1, 1023, 1};
	int phase_nx   [NUM_PHASES] = '{2, 1, 3, 1, 1, 1023, 0};
	int phase_er   [NUM_PHASES] = '{3, 1023, 1, 7, 1, 1023, 2};
	int phase_win  [NUM_PHASES] = '{4, 1, 0, 3600, 15, 4095, 15};
	int phase_slip [NUM_PHASES] = '{2, 0, 1, 10, 2, 15, 3};

	per_client_response_token_bucket uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	pcrtb_decision_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatch_count),
		.pending    (pending_results)
	);

	always #4 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic apb_write(input logic [2:0] reg_idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input int okr, input int nxr, input int err, input int win,
			input int slip);
		apb_write(REG_OK_RATE, okr);
		apb_write(REG_NX_RATE, nxr);
		apb_write(REG_ER_RATE, err);
		apb_write(REG_WINDOW, win);
		apb_write(REG_SLIP, slip);
	endtask

	task automatic send_request(input int idx, input logic [1:0] cls,
			input logic [TIME_W-1:0] now, input bit rec);
		if (items_sent >= 2 * MODE_ITEMS) begin
			send_idle = 0;
			recv_idle = 0;
		end else if (items_sent >= MODE_ITEMS) begin
			send_idle = 56;
			recv_idle = 37;
		end
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - ADDR_W - TIME_W){1'b0}}, now, idx[ADDR_W-1:0]};
		s_tuser <= {rec, cls};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [TIME_W-1:0] now;
		int hot_idx [8];
		int idx;
		int roll;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// every rate is zero out of reset
		send_request(3, CLS_OK, 32'd0, 1'b1);
		send_request(1023, CLS_ERR, 32'hFFFF_FFFF, 1'b0);
		drain_results();
		configure(1, 0, 1023, 3, 2);

		// debt, slip, skew handling on one entry
		send_request(0, CLS_OK, 32'd100, 1'b0);
		send_request(0, CLS_OK, 32'd100, 1'b0);
		send_request(0, CLS_OK, 32'd100, 1'b0);
		send_request(0, CLS_OK, 32'd100, 1'b0);
		send_request(0, CLS_OK, 32'd98, 1'b0);
		send_request(0, CLS_OK, 32'd101, 1'b0);
		send_request(0, CLS_OK, 32'd50, 1'b0);
		// recycle on a disabled class still clears the last use
		send_request(3, CLS_OK, 32'd1000, 1'b0);
		send_request(3, CLS_NX, 32'd1000, 1'b1);
		send_request(3, CLS_OK, 32'd1001, 1'b0);
		// time extremes and the spare class
		send_request(1023, CLS_ERR, 32'hFFFF_FFFF, 1'b1);
		send_request(1023, CLS_ERR, 32'hFFFF_FFFF, 1'b0);
		send_request(1023, CLS_SPARE, 32'h8000_0000, 1'b0);
		send_request(1023, CLS_SPARE, 32'h7FFF_FFFF, 1'b0);
		send_request(5, CLS_SPARE, 32'd7, 1'b0);
		send_request(5, CLS_ERR, 32'd7, 1'b1);
		send_request(512, CLS_OK, 32'd0, 1'b1);

		for (int k = 0; k < 8; k++)
			hot_idx[k] = $urandom_range(ENTRIES - 1);
		hot_idx[0] = 0;
		hot_idx[1] = ENTRIES - 1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			configure(phase_ok[p], phase_nx[p], phase_er[p], phase_win[p], phase_slip[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 80)
					idx = hot_idx[$urandom_range(7)];
				else
					idx = $urandom_range(ENTRIES - 1);
				now = entry_time[idx];
				roll = $urandom_range(99);
				if (roll < 30)
					now = now + 1;
				else if (roll < 40)
					now = now + $urandom_range(phase_win[p] + 3, 2);
				else if (roll < 45)
					now = now - $urandom_range(5, 1);
				else if (roll < 48)
					now = now - $urandom_range(32'h7FFF_FFFF, 6);
				else if (roll < 51)
					now = $urandom();
				else if (roll < 55)
					now = now + phase_win[p] + $urandom_range(100, 1);
				entry_time[idx] = now;
				send_request(idx, 2'($urandom_range(3)), now, ($urandom_range(99) < 10));
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("per_client_response_token_bucket: match");
		else
			$display("per_client_response_token_bucket: mismatch");
		$finish;
	end

	initial begin
		#4ms;
		$display("per_client_response_token_bucket: mismatch");
		$finish;
	end

endmodule

// ===== per_client_response_token_bucket.f =====
+incdir+hw/rtl
hw/rtl/pcrtb_pkg.sv
hw/rtl/pcrtb_ram.sv
hw/rtl/per_client_response_token_bucket.sv
tb/sv/pcrtb_decision_checker.sv
tb/sv/tb_per_client_response_token_bucket.sv
